@@ hw/rtl/ssi_pkg.sv @@
// Shared widths and pipeline record types for the segment/sphere intersection core.
// Used by the cells and the core under hw/rtl; depends on nothing.
package ssi_pkg;

    // Field widths of the input and result beats.
    localparam int COORD_W   = 32;
    localparam int RAD_W     = 31;
    localparam int TIME_BITS = 16;
    localparam int TIME_W    = TIME_BITS + 1;

    // Internal widths: differences, products and the wide magnitudes.
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int MAG_W     = PROD_W;
    localparam int E_W       = MAG_W + 1;
    localparam int Q_W       = E_W + 1;
    localparam int DISC_W    = 2 * MAG_W + 2;
    localparam int ROOT_BITS = MAG_W - 2;
    localparam int SQ_W      = 2 * ROOT_BITS;
    localparam int DIV_W     = MAG_W + TIME_BITS;
    localparam int PT_W      = DIFF_W + TIME_W + 1;

    // Start point and direction of one segment, lane 0 is x.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] p0;
        logic [2:0][DIFF_W-1:0]  d;
    } geom_t;

    // Record that travels along the divider cells.
    typedef struct packed {
        logic              valid;
        logic              miss;
        geom_t             geom;
        logic [MAG_W-1:0]  l2;
    } pt_ctl_t;

    // Record that travels along the square-root cells.
    typedef struct packed {
        pt_ctl_t              base;
        logic signed [E_W-1:0] e;
    } sq_ctl_t;

endpackage

@@ hw/rtl/ssi_mul.sv @@
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on nothing outside this file.
module ssi_mul #(
    parameter int W = 66
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] p
);
    localparam int H = (W + 1) / 2;

    logic [2*H-1:0] a_ext, b_ext;
    logic [2*H-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [4*H-1:0] sum;
    logic [2*W-1:0] p_next, p_reg;

    assign a_ext = (2*H)'(a);
    assign b_ext = (2*H)'(b);

    // First stage: the four partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= a_ext[H-1:0]   * b_ext[H-1:0];
            lh_reg <= a_ext[H-1:0]   * b_ext[2*H-1:H];
            hl_reg <= a_ext[2*H-1:H] * b_ext[H-1:0];
            hh_reg <= a_ext[2*H-1:H] * b_ext[2*H-1:H];
        end
    end

    // Second stage: align and add the partial products.
    always_comb begin
        sum    = {hh_reg, ll_reg} + ((4*H)'(lh_reg) << H) + ((4*H)'(hl_reg) << H);
        p_next = sum[2*W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/ssi_sqrt_cell.sv @@
// One cell of the square-root chain: decides one root bit per cycle while en is high.
// Depends on ssi_pkg for widths and the sq_ctl_t record.
module ssi_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  ssi_pkg::sq_ctl_t               ctl_in,
    input  logic [ssi_pkg::SQ_W-1:0]       rem_in,
    input  logic [ssi_pkg::ROOT_BITS-1:0]  root_in,
    output ssi_pkg::sq_ctl_t               ctl_out,
    output logic [ssi_pkg::SQ_W-1:0]       rem_out,
    output logic [ssi_pkg::ROOT_BITS-1:0]  root_out
);
    localparam int SQ_W      = ssi_pkg::SQ_W;
    localparam int ROOT_BITS = ssi_pkg::ROOT_BITS;

    logic [SQ_W-1:0]      trial, rem_next, rem_reg;
    logic [ROOT_BITS-1:0] root_next, root_reg;
    logic                 take;
    logic                 valid_reg;
    ssi_pkg::sq_ctl_t     ctl_reg;

    // Try setting this bit: (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b).
    always_comb begin
        trial     = (SQ_W'(root_in) << (BIT + 1)) | (SQ_W'(1) << (2 * BIT));
        take      = (rem_in >= trial);
        rem_next  = take ? (rem_in - trial) : rem_in;
        root_next = root_in | (ROOT_BITS'(take) << BIT);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg  <= ctl_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_in.base.valid;
        end
    end

    always_comb begin
        ctl_out            = ctl_reg;
        ctl_out.base.valid = valid_reg;
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

@@ hw/rtl/ssi_div_cell.sv @@
// One cell of the restoring divider chain: decides one quotient bit per cycle while en is high.
// Depends on ssi_pkg for widths and the pt_ctl_t record.
module ssi_div_cell #(
    parameter int BIT = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  ssi_pkg::pt_ctl_t             ctl_in,
    input  logic [ssi_pkg::DIV_W-1:0]    rem_in,
    input  logic [ssi_pkg::TIME_W-1:0]   quo_in,
    output ssi_pkg::pt_ctl_t             ctl_out,
    output logic [ssi_pkg::DIV_W-1:0]    rem_out,
    output logic [ssi_pkg::TIME_W-1:0]   quo_out
);
    localparam int DIV_W  = ssi_pkg::DIV_W;
    localparam int TIME_W = ssi_pkg::TIME_W;

    logic [DIV_W-1:0]  trial, rem_next, rem_reg;
    logic [TIME_W-1:0] quo_next, quo_reg;
    logic              take;
    logic              valid_reg;
    ssi_pkg::pt_ctl_t  ctl_reg;

    // Subtract the shifted divisor where it fits and record the bit.
    // A zero divisor (zero-length segment) sets no bit, so its time stays at 0.
    always_comb begin
        trial    = DIV_W'(ctl_in.l2) << BIT;
        take     = (trial != '0) && (rem_in >= trial);
        rem_next = take ? (rem_in - trial) : rem_in;
        quo_next = quo_in | (TIME_W'(take) << BIT);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg <= ctl_in;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_comb begin
        ctl_out       = ctl_reg;
        ctl_out.valid = valid_reg;
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

@@ hw/rtl/segment_sphere_intersect_core.sv @@
// Segment against sphere test, fully pipelined: one beat is accepted per cycle while the
// pipeline is not held. The pipeline is made of two cell chains, 64 square-root cells
// (one root bit each) and 17 divider cells (one time bit each), plus the front-end products
// and the two-stage wide multipliers. The whole pipeline advances together; it holds only
// while a result sits in the output register and m_ready is low.
module segment_sphere_intersect_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_p0_x,
    input  logic signed [31:0] s_p0_y,
    input  logic signed [31:0] s_p0_z,
    input  logic signed [31:0] s_p1_x,
    input  logic signed [31:0] s_p1_y,
    input  logic signed [31:0] s_p1_z,
    input  logic signed [31:0] s_centre_x,
    input  logic signed [31:0] s_centre_y,
    input  logic signed [31:0] s_centre_z,
    input  logic [30:0]        s_radius,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [16:0]        m_contact_time,
    output logic signed [31:0] m_contact_x,
    output logic signed [31:0] m_contact_y,
    output logic signed [31:0] m_contact_z
);
    localparam int COORD_W   = ssi_pkg::COORD_W;
    localparam int RAD_W     = ssi_pkg::RAD_W;
    localparam int DIFF_W    = ssi_pkg::DIFF_W;
    localparam int PROD_W    = ssi_pkg::PROD_W;
    localparam int MAG_W     = ssi_pkg::MAG_W;
    localparam int E_W       = ssi_pkg::E_W;
    localparam int Q_W       = ssi_pkg::Q_W;
    localparam int DISC_W    = ssi_pkg::DISC_W;
    localparam int ROOT_BITS = ssi_pkg::ROOT_BITS;
    localparam int SQ_W      = ssi_pkg::SQ_W;
    localparam int DIV_W     = ssi_pkg::DIV_W;
    localparam int TIME_BITS = ssi_pkg::TIME_BITS;
    localparam int TIME_W    = ssi_pkg::TIME_W;
    localparam int PT_W      = ssi_pkg::PT_W;

    logic adv;

    // Global advance: everything moves unless the output beat is stuck.
    assign adv     = !m_valid | m_ready;
    assign s_ready = adv;

    // ---------------------------------------------------------------- stage 1
    logic [2:0][COORD_W-1:0] p0_in, p1_in, cen_in;
    logic [2:0][DIFF_W-1:0]  d1_next, m1_next;
    logic [2:0][COORD_W-1:0] p0_1_reg;
    logic [2:0][DIFF_W-1:0]  d1_reg, m1_reg;
    logic [RAD_W-1:0]        rad1_reg;
    logic                    v1_reg;

    assign p0_in  = {s_p0_z, s_p0_y, s_p0_x};
    assign p1_in  = {s_p1_z, s_p1_y, s_p1_x};
    assign cen_in = {s_centre_z, s_centre_y, s_centre_x};

    // Direction d = p1 - p0 and offset m = p0 - centre, one bit wider.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d1_next[i] = {p1_in[i][COORD_W-1], p1_in[i]} - {p0_in[i][COORD_W-1], p0_in[i]};
            m1_next[i] = {p0_in[i][COORD_W-1], p0_in[i]} - {cen_in[i][COORD_W-1], cen_in[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_1_reg <= p0_in;
            d1_reg   <= d1_next;
            m1_reg   <= m1_next;
            rad1_reg <= s_radius;
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic [2:0][PROD_W-1:0]  md_next, mm_next, dd_next;
    logic [2:0][PROD_W-1:0]  md2_reg, mm2_reg, dd2_reg;
    logic [2*RAD_W-1:0]      rr2_reg;
    ssi_pkg::geom_t          geom2_reg;
    logic                    v2_reg;

    // The nine lane products and the squared radius.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            md_next[i] = $signed(m1_reg[i]) * $signed(d1_reg[i]);
            mm_next[i] = $signed(m1_reg[i]) * $signed(m1_reg[i]);
            dd_next[i] = $signed(d1_reg[i]) * $signed(d1_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            md2_reg      <= md_next;
            mm2_reg      <= mm_next;
            dd2_reg      <= dd_next;
            rr2_reg      <= rad1_reg * rad1_reg;
            geom2_reg.p0 <= p0_1_reg;
            geom2_reg.d  <= d1_reg;
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic signed [E_W-1:0] e3_next, c3_next;
    logic [MAG_W-1:0]      mm3_sum, l2_3_next, eabs3_next, cabs3_next;
    logic                  c_pos, e_pos, l2_zero, miss3_next;
    logic signed [E_W-1:0] e3_reg;
    logic [MAG_W-1:0]      eabs3_reg, cabs3_reg, l2_3_reg;
    logic                  cneg3_reg, miss3_reg, v3_reg;
    ssi_pkg::geom_t        geom3_reg;

    // Sums e = m.d, |m|^2, L2 = |d|^2, then c = |m|^2 - r^2 and the early rejects.
    always_comb begin
        e3_next    = E_W'($signed(md2_reg[0])) + E_W'($signed(md2_reg[1]))
                   + E_W'($signed(md2_reg[2]));
        mm3_sum    = mm2_reg[0] + mm2_reg[1] + mm2_reg[2];
        l2_3_next  = dd2_reg[0] + dd2_reg[1] + dd2_reg[2];
        c3_next    = $signed({1'b0, mm3_sum}) - $signed(E_W'(rr2_reg));
        c_pos      = !c3_next[E_W-1] && (c3_next != '0);
        e_pos      = !e3_next[E_W-1] && (e3_next != '0);
        l2_zero    = (l2_3_next == '0);
        miss3_next = c_pos && (e_pos || l2_zero);
        eabs3_next = e3_next[E_W-1] ? MAG_W'(-e3_next) : MAG_W'(e3_next);
        cabs3_next = c3_next[E_W-1] ? MAG_W'(-c3_next) : MAG_W'(c3_next);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e3_reg    <= e3_next;
            eabs3_reg <= eabs3_next;
            cabs3_reg <= cabs3_next;
            cneg3_reg <= c3_next[E_W-1];
            l2_3_reg  <= l2_3_next;
            miss3_reg <= miss3_next;
            geom3_reg <= geom2_reg;
        end
    end

    // ---------------------------------------------------------- stages 4 and 5
    logic [2*MAG_W-1:0] e2_prod, cl2_prod;
    ssi_pkg::sq_ctl_t   side3, side4_reg, side5_reg;
    logic               cneg4_reg, cneg5_reg, v4_reg, v5_reg;

    ssi_mul #(.W(MAG_W)) u_mul_ee (
        .aclk (aclk),
        .en   (adv),
        .a    (eabs3_reg),
        .b    (eabs3_reg),
        .p    (e2_prod)
    );

    ssi_mul #(.W(MAG_W)) u_mul_cl (
        .aclk (aclk),
        .en   (adv),
        .a    (cabs3_reg),
        .b    (l2_3_reg),
        .p    (cl2_prod)
    );

    always_comb begin
        side3.base.valid = v3_reg;
        side3.base.miss  = miss3_reg;
        side3.base.geom  = geom3_reg;
        side3.base.l2    = l2_3_reg;
        side3.e          = e3_reg;
    end

    // Side data waits alongside the two multiplier stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            side4_reg <= side3;
            side5_reg <= side4_reg;
            cneg4_reg <= cneg3_reg;
            cneg5_reg <= cneg4_reg;
        end
    end

    // ---------------------------------------------------------------- stage 6
    logic signed [DISC_W-1:0] disc;
    ssi_pkg::sq_ctl_t         ctl6_next, ctl6_reg;
    logic [SQ_W-1:0]          rem6_reg;
    logic                     v6_reg;

    // Discriminant e^2 - c * L2; a negative one is a miss.
    always_comb begin
        if (cneg5_reg) begin
            disc = $signed(DISC_W'(e2_prod)) + $signed(DISC_W'(cl2_prod));
        end else begin
            disc = $signed(DISC_W'(e2_prod)) - $signed(DISC_W'(cl2_prod));
        end
        ctl6_next           = side5_reg;
        ctl6_next.base.miss = side5_reg.base.miss | disc[DISC_W-1];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl6_reg <= ctl6_next;
            rem6_reg <= disc[SQ_W-1:0];
        end
    end

    // ------------------------------------------------------ square-root chain
    ssi_pkg::sq_ctl_t     sq_head;
    ssi_pkg::sq_ctl_t     sq_ctl  [0:ROOT_BITS];
    logic [SQ_W-1:0]      sq_rem  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] sq_root [0:ROOT_BITS];

    always_comb begin
        sq_head            = ctl6_reg;
        sq_head.base.valid = v6_reg;
    end
    assign sq_ctl[0]  = sq_head;
    assign sq_rem[0]  = rem6_reg;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
        ssi_sqrt_cell #(.BIT(ROOT_BITS - 1 - k)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .ctl_in   (sq_ctl[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .ctl_out  (sq_ctl[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1])
        );
    end

    // ---------------------------------------------------------------- stage 7
    logic signed [Q_W-1:0] q;
    logic                  q_pos, q_over;
    ssi_pkg::pt_ctl_t      ctl7_next, ctl7_reg;
    logic [DIV_W-1:0]      rem7_next, rem7_reg;

    // Q = -e - floor(sqrt(D)); Q <= 0 gives time 0, Q > L2 is a miss.
    always_comb begin
        q         = -Q_W'(sq_ctl[ROOT_BITS].e) - $signed(Q_W'(sq_root[ROOT_BITS]));
        q_pos     = !q[Q_W-1] && (q != '0);
        q_over    = q_pos && (q > $signed(Q_W'(sq_ctl[ROOT_BITS].base.l2)));
        ctl7_next = sq_ctl[ROOT_BITS].base;
        ctl7_next.miss = sq_ctl[ROOT_BITS].base.miss | q_over;
        rem7_next = q_pos ? (DIV_W'(q[MAG_W-1:0]) << TIME_BITS) : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl7_reg <= ctl7_next;
            rem7_reg <= rem7_next;
        end
    end

    // ---------------------------------------------------------- divider chain
    ssi_pkg::pt_ctl_t  dv_head;
    ssi_pkg::pt_ctl_t  dv_ctl [0:TIME_W];
    logic [DIV_W-1:0]  dv_rem [0:TIME_W];
    logic [TIME_W-1:0] dv_quo [0:TIME_W];
    logic              v7_reg;

    always_comb begin
        dv_head       = ctl7_reg;
        dv_head.valid = v7_reg;
    end
    assign dv_ctl[0] = dv_head;
    assign dv_rem[0] = rem7_reg;
    assign dv_quo[0] = '0;

    for (genvar k = 0; k < TIME_W; k++) begin : g_div
        ssi_div_cell #(.BIT(TIME_W - 1 - k)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .ctl_in  (dv_ctl[k]),
            .rem_in  (dv_rem[k]),
            .quo_in  (dv_quo[k]),
            .ctl_out (dv_ctl[k+1]),
            .rem_out (dv_rem[k+1]),
            .quo_out (dv_quo[k+1])
        );
    end

    // ---------------------------------------------------------------- stage 8
    logic [2:0][PT_W-1:0]    prod8_next, prod8_reg;
    logic [2:0][COORD_W-1:0] p0_8_reg;
    logic [TIME_W-1:0]       tq8_reg;
    logic                    hit8_reg, v8_reg;

    // Lane products d * time.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod8_next[i] = $signed(dv_ctl[TIME_W].geom.d[i])
                          * $signed({1'b0, dv_quo[TIME_W]});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod8_reg <= prod8_next;
            p0_8_reg  <= dv_ctl[TIME_W].geom.p0;
            tq8_reg   <= dv_quo[TIME_W];
            hit8_reg  <= !dv_ctl[TIME_W].miss;
        end
    end

    // ------------------------------------------------------------ output stage
    logic [2:0][PT_W-1:0]    pt_sum;
    logic [2:0][COORD_W-1:0] pt_next, pt_reg;
    logic [TIME_W-1:0]       time_reg;
    logic                    hit_reg, m_valid_reg;

    // Point p0 + floor(d * time / 2^16); a miss reports all zeros.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt_sum[i]  = PT_W'($signed(p0_8_reg[i])) + ($signed(prod8_reg[i]) >>> TIME_BITS);
            pt_next[i] = hit8_reg ? pt_sum[i][COORD_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pt_reg   <= pt_next;
            time_reg <= hit8_reg ? tq8_reg : '0;
            hit_reg  <= hit8_reg;
        end
    end

    // Beat-valid flags of the top-level stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= sq_ctl[ROOT_BITS].base.valid;
            v8_reg      <= dv_ctl[TIME_W].valid;
            m_valid_reg <= v8_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = hit_reg;
    assign m_contact_time = time_reg;
    assign m_contact_x    = pt_reg[0];
    assign m_contact_y    = pt_reg[1];
    assign m_contact_z    = pt_reg[2];

    // ------------------------------------------------------------- assertions
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_contact_time == '0 && m_contact_x == '0
                                 && m_contact_y == '0 && m_contact_z == '0))
        else $error("miss beat carries non-zero result fields");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_contact_time <= (TIME_W'(1) << TIME_BITS)))
        else $error("contact time above 1.0");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while the pipeline is held");

    a_hold_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_contact_time) && $stable(m_hit)))
        else $error("held result changed");

endmodule

@@ tb/sv/tb_segment_sphere_intersect_core.sv @@
// Self-checking testbench for segment_sphere_intersect_core: a bit-exact predictor,
// random idling on both channels and a long output stall. Depends on ssi_pkg and the core.
`timescale 1ns / 1ps
module tb_segment_sphere_intersect_core;
    localparam int COORD_W   = ssi_pkg::COORD_W;
    localparam int RAD_W     = ssi_pkg::RAD_W;
    localparam int TIME_BITS = ssi_pkg::TIME_BITS;
    localparam int TIME_W    = ssi_pkg::TIME_W;

    typedef logic signed [159:0] wide_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        logic               hit;
        logic [TIME_W-1:0]  t;
        coord_t             x, y, z;
    } contact_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    coord_t             s_p0_x = '0, s_p0_y = '0, s_p0_z = '0;
    coord_t             s_p1_x = '0, s_p1_y = '0, s_p1_z = '0;
    coord_t             s_centre_x = '0, s_centre_y = '0, s_centre_z = '0;
    logic [RAD_W-1:0]   s_radius = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_hit;
    logic [TIME_W-1:0]  m_contact_time;
    coord_t             m_contact_x, m_contact_y, m_contact_z;

    contact_t           contact_q[$];
    int                 errors = 0;
    int                 sent = 0;
    int                 hits_seen = 0;
    int                 results_seen = 0;
    int                 stall_cycles = 0;
    bit                 tx_idle_on = 1'b1;
    bit                 rx_idle_on = 1'b1;
    bit                 hold_req = 1'b0;

    segment_sphere_intersect_core DUT (.*);

    // Clock.
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Exact contact prediction with wide integers.
    function automatic contact_t predict_contact(coord_t a[3], coord_t b[3], coord_t cen[3],
                                                 logic [RAD_W-1:0] rad);
        contact_t res;
        longint p0[3], d[3], m[3];
        wide_t e, mm, l2, c, disc, root, cand, q, qs;
        logic [TIME_W-1:0] tq;
        longint pr;
        e = 0; mm = 0; l2 = 0; tq = '0;
        res = '{hit: 1'b0, t: '0, x: '0, y: '0, z: '0};
        for (int i = 0; i < 3; i++) begin
            p0[i] = longint'(a[i]);
            d[i]  = longint'(b[i]) - p0[i];
            m[i]  = p0[i] - longint'(cen[i]);
            e  += wide_t'(m[i]) * wide_t'(d[i]);
            mm += wide_t'(m[i]) * wide_t'(m[i]);
            l2 += wide_t'(d[i]) * wide_t'(d[i]);
        end
        c = mm - wide_t'(rad) * wide_t'(rad);
        if (l2 == 0) begin
            if (c > 0) return res;
        end else begin
            if (c > 0 && e > 0) return res;
            disc = e * e - c * l2;
            if (disc < 0) return res;
            root = 0;
            for (int bt = 67; bt >= 0; bt--) begin
                cand = root | (wide_t'(1) << bt);
                if (cand * cand <= disc) root = cand;
            end
            q = -e - root;
            if (q > 0) begin
                if (q > l2) return res;
                qs = q << TIME_BITS;
                for (int bt = TIME_BITS; bt >= 0; bt--) begin
                    cand = wide_t'(tq | (17'd1 << bt));
                    if (cand * l2 <= qs) tq = tq | (17'd1 << bt);
                end
            end
        end
        res.hit = 1'b1;
        res.t = tq;
        pr = d[0] * longint'(tq); res.x = coord_t'(p0[0] + (pr >>> TIME_BITS));
        pr = d[1] * longint'(tq); res.y = coord_t'(p0[1] + (pr >>> TIME_BITS));
        pr = d[2] * longint'(tq); res.z = coord_t'(p0[2] + (pr >>> TIME_BITS));
        return res;
    endfunction

    // Offer one segment and wait until the beat is taken; valid is left high unless a random idle follows.
    task automatic send_segment(coord_t a[3], coord_t b[3], coord_t cen[3],
                                logic [RAD_W-1:0] rad);
        bit taken;
        s_valid <= 1'b1;
        s_p0_x <= a[0]; s_p0_y <= a[1]; s_p0_z <= a[2];
        s_p1_x <= b[0]; s_p1_y <= b[1]; s_p1_z <= b[2];
        s_centre_x <= cen[0]; s_centre_y <= cen[1]; s_centre_z <= cen[2];
        s_radius <= rad;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            if (taken) contact_q.push_back(predict_contact(a, b, cen, rad));
            @(posedge aclk);
        end
        sent++;
        if (tx_idle_on && ($urandom % 4 == 0)) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // A segment aimed through a sphere, at a random scale and position; about one in eight is zero-length.
    task automatic send_aimed_segment();
        coord_t a[3], b[3], cen[3];
        int sh;
        logic [RAD_W-1:0] rad;
        sh = $urandom_range(2, 24);
        for (int i = 0; i < 3; i++) begin
            cen[i] = coord_t'($urandom) >>> $urandom_range(0, 12);
            a[i] = cen[i] + (coord_t'($urandom) >>> sh);
            b[i] = cen[i] - (coord_t'($urandom) >>> sh) + (coord_t'($urandom) >>> (sh + 2));
        end
        rad = RAD_W'($urandom) >> ($urandom_range(0, 7) + sh - 2);
        if ($urandom % 8 == 0) b = a;
        send_segment(a, b, cen, rad);
    endtask

    // Fully random beat: covers every bit of every field.
    task automatic send_noise_segment();
        coord_t a[3], b[3], cen[3];
        for (int i = 0; i < 3; i++) begin
            a[i] = coord_t'($urandom);
            b[i] = coord_t'($urandom);
            cen[i] = coord_t'($urandom);
        end
        send_segment(a, b, cen, RAD_W'($urandom));
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end else if (rx_idle_on && ($urandom % 4 == 0)) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Result checker: compare each taken beat with the oldest prediction.
    always @(negedge aclk) begin
        contact_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (contact_q.size() == 0) begin
                $display("%0t: unexpected result beat hit=%0d", $time, m_hit);
                errors++;
            end else begin
                exp_c = contact_q.pop_front();
                if (m_hit) hits_seen++;
                if (m_hit !== exp_c.hit || m_contact_time !== exp_c.t ||
                    m_contact_x !== exp_c.x || m_contact_y !== exp_c.y ||
                    m_contact_z !== exp_c.z) begin
                    $display("%0t: mismatch expected hit=%0d t=%0d p=(%0d,%0d,%0d)",
                             $time, exp_c.hit, exp_c.t, exp_c.x, exp_c.y, exp_c.z);
                    $display("%0t:          actual   hit=%0d t=%0d p=(%0d,%0d,%0d)",
                             $time, m_hit, m_contact_time, m_contact_x, m_contact_y,
                             m_contact_z);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles without any beat on either channel.
    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 3000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Corner cases: extremes, zero-length, start inside, grazing, pointing away.
    task automatic test_directed();
        coord_t one;
        one = coord_t'(32'h0001_0000);
        send_segment('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff},
                     '{32'h80000000, 32'h80000000, 32'h80000000}, '{0, 0, 0}, 31'h7fffffff);
        send_segment('{32'h80000000, 32'h80000000, 32'h80000000},
                     '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff},
                     '{32'h7fffffff, 32'h80000000, 0}, 31'h0);
        send_segment('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, 31'h0);
        send_segment('{one, 0, 0}, '{one, 0, 0}, '{0, 0, 0}, 31'h0001_0000);
        send_segment('{2 * one, 0, 0}, '{2 * one, 0, 0}, '{0, 0, 0}, 31'h0001_0000);
        send_segment('{0, 0, 0}, '{4 * one, 0, 0}, '{0, 0, 0}, 31'h0002_0000);
        send_segment('{0, 0, 0}, '{2 * one, 0, 0}, '{3 * one, 0, 0}, 31'h0001_0000);
        send_segment('{0, one, 0}, '{2 * one, one, 0}, '{one, 0, 0}, 31'h0001_0000);
        send_segment('{-4 * one, 0, 0}, '{4 * one, 0, 0}, '{0, 0, 0}, 31'h0001_0000);
        send_segment('{2 * one, 0, 0}, '{4 * one, 0, 0}, '{0, 0, 0}, 31'h0001_0000);
        send_segment('{-4 * one, 3 * one, 0}, '{4 * one, 3 * one, 0}, '{0, 0, 0},
                     31'h0001_0000);
        send_segment('{-4 * one, 0, 0}, '{-2 * one, 0, 0}, '{0, 0, 0}, 31'h0001_0000);
        send_segment('{0, 0, 32'h7fffffff}, '{0, 0, 32'h80000000}, '{0, 0, 0}, 31'h7fffffff);
        send_segment('{1, 1, 1}, '{-1, -1, -1}, '{0, 0, 0}, 31'h1);
    endtask

    task automatic test_random_aimed();
        repeat (150) send_aimed_segment();
    endtask

    task automatic test_random_noise();
        repeat (80) send_noise_segment();
    endtask

    // Long output stall while the sender keeps offering beats.
    task automatic test_back_pressure();
        tx_idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (150) send_aimed_segment();
        tx_idle_on = 1'b1;
    endtask

    // Final stretch at full rate with no idling on either side.
    task automatic test_streaming();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (60) begin
            if ($urandom % 3 == 0) send_noise_segment();
            else send_aimed_segment();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_aimed();
        test_random_noise();
        test_back_pressure();
        test_streaming();
        s_valid <= 1'b0;
        while (contact_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d segments, checked %0d results, %0d of them hits.",
                 sent, results_seen, hits_seen);
        $display("Covered corner cases, aimed and random segments, a long stall, full rate.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ssi_pkg.sv
hw/rtl/ssi_mul.sv
hw/rtl/ssi_sqrt_cell.sv
hw/rtl/ssi_div_cell.sv
hw/rtl/segment_sphere_intersect_core.sv
tb/sv/tb_segment_sphere_intersect_core.sv
